>>> rtl/btnev_pkg.sv
// btnev_pkg: shared types and constants for the button event block
// used by btnev_csr, btnev_cell and button_event_long_press_repeat
`default_nettype none

package btnev_pkg;

   // field widths fixed by the interface
   localparam int PIN_WIDTH      = 8;
   localparam int TICK_WIDTH     = 8;
   localparam int CSR_IDX_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH = 8;

   // register indexes on the csr port
   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_DEBOUNCE_TICKS   = 3'd0,
      CSR_LONG_PRESS_TICKS = 3'd1,
      CSR_REPEAT_TICKS     = 3'd2,
      CSR_ENABLE_MASK      = 3'd3,
      CSR_ACTIVE_LOW       = 3'd4
   } csr_index_type;

   // register reset values
   localparam logic [TICK_WIDTH-1:0] DEBOUNCE_RESET   = 8'd1;
   localparam logic [TICK_WIDTH-1:0] LONG_PRESS_RESET = 8'd0;
   localparam logic [TICK_WIDTH-1:0] REPEAT_RESET     = 8'd0;
   localparam logic [PIN_WIDTH-1:0]  ENABLE_RESET     = 8'hFF;
   localparam logic                  ACTIVE_LOW_RESET = 1'b1;
   localparam logic [TICK_WIDTH-1:0] INTERVAL_RESET   = 8'd1;

   // programmed settings
   typedef struct packed {
      logic [TICK_WIDTH-1:0] debounce_ticks;
      logic [TICK_WIDTH-1:0] long_press_ticks;
      logic [TICK_WIDTH-1:0] repeat_ticks;
      logic [PIN_WIDTH-1:0]  enable_mask;
      logic                  active_low;
   } cfg_type;

   // per-button control for one tick
   typedef struct packed {
      logic tick;   // a beat is processed this cycle
      logic eval;   // this tick evaluates button state
      logic live;   // button is enabled
      logic rise;   // newly pressed
      logic fall;   // newly released
   } cell_ctl_type;

   // per-button marks for one tick
   typedef struct packed {
      logic long_mark;
      logic repeat_mark;
   } cell_evt_type;

endpackage

`default_nettype wire

>>> rtl/btnev_csr.sv
// btnev_csr: configuration registers of the button event block
// depends on btnev_pkg
`default_nettype none

module btnev_csr (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [btnev_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  wire logic [btnev_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output btnev_pkg::cfg_type                         cfg
);

   btnev_pkg::cfg_type cfg_ff;
   btnev_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            btnev_pkg::CSR_DEBOUNCE_TICKS:   cfg_in.debounce_ticks   = csr_wdata;
            btnev_pkg::CSR_LONG_PRESS_TICKS: cfg_in.long_press_ticks = csr_wdata;
            btnev_pkg::CSR_REPEAT_TICKS:     cfg_in.repeat_ticks     = csr_wdata;
            btnev_pkg::CSR_ENABLE_MASK:      cfg_in.enable_mask      = csr_wdata;
            btnev_pkg::CSR_ACTIVE_LOW:       cfg_in.active_low       = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks   <= btnev_pkg::DEBOUNCE_RESET;
         cfg_ff.long_press_ticks <= btnev_pkg::LONG_PRESS_RESET;
         cfg_ff.repeat_ticks     <= btnev_pkg::REPEAT_RESET;
         cfg_ff.enable_mask      <= btnev_pkg::ENABLE_RESET;
         cfg_ff.active_low       <= btnev_pkg::ACTIVE_LOW_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/btnev_cell.sv
// btnev_cell: one button's timer, held and long-press arming state
// depends on btnev_pkg
`default_nettype none

module btnev_cell (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire btnev_pkg::cell_ctl_type              ctl,
   input  wire logic [btnev_pkg::TICK_WIDTH-1:0]     long_press_ticks,
   input  wire logic [btnev_pkg::TICK_WIDTH-1:0]     repeat_ticks,
   output btnev_pkg::cell_evt_type                   evt
);

   logic [btnev_pkg::TICK_WIDTH-1:0] timer_ff, timer_in, timer_dec;
   logic                             held_ff, held_in;
   logic                             armed_ff, armed_in;
   logic                             long_on, repeat_on;

   assign long_on   = (long_press_ticks != '0);
   assign repeat_on = (repeat_ticks != '0);

   // countdown, then press handling and mark generation on an evaluating tick
   always_comb begin
      timer_dec = timer_ff;
      if (ctl.live && (timer_ff != '0)) begin
         timer_dec = timer_ff - 1'b1;
      end
      timer_in        = timer_dec;
      held_in         = held_ff;
      armed_in        = armed_ff;
      evt.long_mark   = 1'b0;
      evt.repeat_mark = 1'b0;
      if (ctl.eval && ctl.live) begin
         if (ctl.rise) begin
            held_in = 1'b1;
            if (long_on) begin
               timer_in = long_press_ticks;
               armed_in = 1'b1;
            end else if (repeat_on) begin
               timer_in = repeat_ticks;
            end
         end else if (ctl.fall) begin
            held_in = 1'b0;
         end
         if ((timer_in == '0) && held_in) begin
            if (armed_in) begin
               armed_in      = 1'b0;
               evt.long_mark = 1'b1;
               if (repeat_on) begin
                  timer_in = repeat_ticks;
               end
            end else if (repeat_on) begin
               evt.repeat_mark = 1'b1;
               timer_in        = repeat_ticks;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ff <= '0;
         held_ff  <= 1'b0;
         armed_ff <= 1'b0;
      end else if (ctl.tick) begin
         timer_ff <= timer_in;
         held_ff  <= held_in;
         armed_ff <= armed_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/button_event_long_press_repeat.sv
// button_event_long_press_repeat: debounced button events with long press and repeat
// path from an accepted req beat to rsp_valid: input register, then result register
// throughput: one tick per cycle unless stalled; button cells update in parallel each tick
// req_stall rises only while the result register holds a beat that rsp_stall keeps
// reset (synchronous, active high): control, config and cell state return to defaults,
// payload registers are not reset; no beat in flight; config port is always ready
`default_nettype none

module button_event_long_press_repeat #(
   parameter int NUM_BUTTONS = 8
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // tick input
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [btnev_pkg::PIN_WIDTH-1:0]       req_pin_sample,
   // result output
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_sampled,
   output logic [btnev_pkg::PIN_WIDTH-1:0]            rsp_pressed_mask,
   output logic [btnev_pkg::PIN_WIDTH-1:0]            rsp_released_mask,
   output logic [btnev_pkg::PIN_WIDTH-1:0]            rsp_long_press_mask,
   output logic [btnev_pkg::PIN_WIDTH-1:0]            rsp_repeat_mask,
   // configuration writes
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [btnev_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  wire logic [btnev_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int PW = btnev_pkg::PIN_WIDTH;
   localparam logic [PW:0] LANE_ALL = (PW+1)'((1 << NUM_BUTTONS) - 1);
   localparam logic [PW-1:0] LANE_MASK = LANE_ALL[PW-1:0];

   btnev_pkg::cfg_type cfg;

   logic                                in_valid_ff, in_valid_in;
   logic [PW-1:0]                       in_sample_ff;
   logic                                out_valid_ff, out_valid_in;
   logic                                out_sampled_ff;
   logic [PW-1:0]                       out_pressed_ff, out_released_ff;
   logic [PW-1:0]                       out_long_ff, out_repeat_ff;
   logic [btnev_pkg::TICK_WIDTH-1:0]    interval_ff, interval_in, interval_dec;
   logic [PW-1:0]                       prev_status_ff;
   logic                                out_free, advance, req_accept, eval;
   logic [PW-1:0]                       live, cur, rise, fall, long_mask, repeat_mask;

   btnev_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // handshake: result register frees when empty or taken
   assign out_free   = !out_valid_ff || !rsp_stall;
   assign advance    = in_valid_ff && out_free;
   assign req_stall  = in_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = advance;
      end
   end

   // interval countdown and evaluation decision
   always_comb begin
      interval_dec = interval_ff;
      if (interval_ff != '0) begin
         interval_dec = interval_ff - 1'b1;
      end
      eval        = (interval_dec == '0);
      interval_in = eval ? cfg.debounce_ticks : interval_dec;
   end

   // sample conditioning and edge detection
   assign live = cfg.enable_mask & LANE_MASK;
   assign cur  = (cfg.active_low ? ~in_sample_ff : in_sample_ff) & live;
   assign rise = eval ? ((prev_status_ff ^ cur) & cur) : '0;
   assign fall = eval ? ((prev_status_ff ^ cur) & prev_status_ff) : '0;

   // per-button cells
   for (genvar i = 0; i < PW; i++) begin : g_btn
      if (i < NUM_BUTTONS) begin : g_cell
         btnev_pkg::cell_ctl_type ctl;
         btnev_pkg::cell_evt_type evt;

         assign ctl.tick = advance;
         assign ctl.eval = eval;
         assign ctl.live = live[i];
         assign ctl.rise = rise[i];
         assign ctl.fall = fall[i];

         btnev_cell u_cell (
            .clock            (clock),
            .reset            (reset),
            .ctl              (ctl),
            .long_press_ticks (cfg.long_press_ticks),
            .repeat_ticks     (cfg.repeat_ticks),
            .evt              (evt)
         );

         assign long_mask[i]   = evt.long_mark;
         assign repeat_mask[i] = evt.repeat_mark;
      end else begin : g_none
         assign long_mask[i]   = 1'b0;
         assign repeat_mask[i] = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         interval_ff    <= btnev_pkg::INTERVAL_RESET;
         prev_status_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            interval_ff <= interval_in;
            if (eval) begin
               prev_status_ff <= cur;
            end
         end
      end
   end

   // input and result payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_sample_ff <= req_pin_sample;
      end
      if (advance) begin
         out_sampled_ff  <= eval;
         out_pressed_ff  <= rise;
         out_released_ff <= fall;
         out_long_ff     <= long_mask;
         out_repeat_ff   <= repeat_mask;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_sampled         = out_sampled_ff;
   assign rsp_pressed_mask    = out_pressed_ff;
   assign rsp_released_mask   = out_released_ff;
   assign rsp_long_press_mask = out_long_ff;
   assign rsp_repeat_mask     = out_repeat_ff;

endmodule

`default_nettype wire

>>> rtl/btnev_chk.sv
// btnev_chk: port-level checks for button_event_long_press_repeat
// depends on btnev_pkg; attached to the top level by the bind below
`default_nettype none

module btnev_chk (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             rsp_valid,
   input  wire logic                             rsp_stall,
   input  wire logic                             rsp_sampled,
   input  wire logic [btnev_pkg::PIN_WIDTH-1:0]  rsp_pressed_mask,
   input  wire logic [btnev_pkg::PIN_WIDTH-1:0]  rsp_released_mask,
   input  wire logic [btnev_pkg::PIN_WIDTH-1:0]  rsp_long_press_mask,
   input  wire logic [btnev_pkg::PIN_WIDTH-1:0]  rsp_repeat_mask
);

   // no result beat right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sampled)
         && $stable(rsp_pressed_mask) && $stable(rsp_released_mask)
         && $stable(rsp_long_press_mask) && $stable(rsp_repeat_mask))
      else $error("stalled result beat changed");

   // ticks without evaluation carry no events
   a_idle_tick_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_sampled |-> (rsp_pressed_mask == '0)
         && (rsp_released_mask == '0) && (rsp_long_press_mask == '0)
         && (rsp_repeat_mask == '0))
      else $error("events reported on a tick that did not sample");

   // a button cannot be pressed and released in one tick
   a_edge_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_pressed_mask & rsp_released_mask) == '0))
      else $error("press and release on the same button");

   // long-press and repeat marks never coincide on a button
   a_mark_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_long_press_mask & rsp_repeat_mask) == '0))
      else $error("long-press and repeat on the same button");

endmodule

bind button_event_long_press_repeat btnev_chk u_btnev_chk (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_sampled         (rsp_sampled),
   .rsp_pressed_mask    (rsp_pressed_mask),
   .rsp_released_mask   (rsp_released_mask),
   .rsp_long_press_mask (rsp_long_press_mask),
   .rsp_repeat_mask     (rsp_repeat_mask)
);

`default_nettype wire
